// File: hdl/fxa_pkg.sv
// Shared types and constants for the Q24.8 fixed-point ALU.
// Used by every module of the block; depends on nothing else.
package fxa_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int FRAC_BITS   = 8;
  localparam int KIND_W      = 4;
  localparam int STAT_W      = 2;
  localparam int NUM_W       = DATA_WIDTH + FRAC_BITS;
  // The divider retires two quotient bits per stage.
  localparam int DIV_STAGES  = (NUM_W + 1) / 2;
  localparam int NUM_PAD     = 2 * DIV_STAGES;
  localparam int PACK_W      = 2 * DATA_WIDTH + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [KIND_W-1:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GT, OP_LT, OP_GE, OP_LE,
    OP_EQ, OP_NE, OP_MIN, OP_MAX, OP_INC, OP_DEC, OP_FROM_INT, OP_TO_INT
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIVZ = 2'd2
  } stat_t;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic        [DATA_WIDTH-1:0] mag_t;

  // A classified item as it waits between the front and the back.
  typedef struct packed {
    op_t   kind;
    data_t a;
    data_t b;
    mag_t  mag_a;
    mag_t  mag_b;
    logic  res_neg;
  } item_t;

endpackage

// File: hdl/fxa_front.sv
// Front end of the fixed-point ALU: takes input transfers and classifies them.
// Depends on fxa_pkg.
module fxa_front (
  input  logic                           in_push,
  input  logic [fxa_pkg::KIND_W-1:0]     in_kind,
  input  logic signed [fxa_pkg::DATA_WIDTH-1:0] in_operand_a,
  input  logic signed [fxa_pkg::DATA_WIDTH-1:0] in_operand_b,
  output logic                           in_full,
  input  logic                           q_full,
  output logic                           q_push,
  output fxa_pkg::item_t                 q_item
);
  import fxa_pkg::*;

  logic a_neg;
  logic b_neg;

  assign a_neg   = in_operand_a[DATA_WIDTH-1];
  assign b_neg   = in_operand_b[DATA_WIDTH-1];
  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

  always_comb begin
    q_item.kind    = op_t'(in_kind);
    q_item.a       = in_operand_a;
    q_item.b       = in_operand_b;
    // Negating the most negative value wraps to its correct unsigned magnitude.
    q_item.mag_a   = a_neg ? mag_t'(-in_operand_a) : mag_t'(in_operand_a);
    q_item.mag_b   = b_neg ? mag_t'(-in_operand_b) : mag_t'(in_operand_b);
    q_item.res_neg = a_neg ^ b_neg;
  end

endmodule

// File: hdl/fxa_queue.sv
// Short queue of classified items between the front and the back.
// Depends on fxa_pkg.
module fxa_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fxa_pkg::item_t push_item,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output fxa_pkg::item_t head
);
  import fxa_pkg::*;

  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_pop;

  assign full   = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty  = (count_r == '0);
  assign head   = mem_r[rd_ptr_r];
  assign do_pop = pop && !empty;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: hdl/fxa_back.sv
// Back end of the fixed-point ALU: executes items in a pipeline that holds a
// radix-4 restoring divider, and keeps the result register. Depends on fxa_pkg.
module fxa_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_empty,
  input  fxa_pkg::item_t                        q_head,
  output logic                                  q_pop,
  input  logic                                  out_pop,
  output logic                                  out_empty,
  output logic signed [fxa_pkg::DATA_WIDTH-1:0] out_result,
  output logic                                  out_compare_true,
  output logic [fxa_pkg::STAT_W-1:0]            out_status
);
  import fxa_pkg::*;

  typedef struct packed {
    op_t                       kind;
    logic                      neg;
    logic                      dz;
    data_t                     res;
    stat_t                     st;
    logic                      cmp;
    logic [2*DATA_WIDTH-1:0]   prod;
    mag_t                      rem;
    logic [NUM_PAD-1:0]        num;
    mag_t                      dvs;
  } stage_t;

  typedef struct packed {
    data_t res;
    stat_t st;
  } pack_t;

  localparam mag_t        SIGN_MAG = mag_t'(1) << (DATA_WIDTH - 1);
  localparam mag_t        MAX_POS  = SIGN_MAG - 1'b1;
  localparam data_t       ONE      = data_t'(1) << FRAC_BITS;
  localparam logic [PACK_W-1:0] HALF = PACK_W'(1) << (FRAC_BITS - 1);

  // One restoring step: returns the new remainder above the shifted numerator.
  function automatic logic [DATA_WIDTH+NUM_PAD-1:0] div_step(
    input mag_t r, input logic [NUM_PAD-1:0] n, input mag_t d);
    logic [DATA_WIDTH:0] t;
    logic [NUM_PAD-1:0]  nn;
    t  = {r, n[NUM_PAD-1]};
    nn = n << 1;
    if (t >= {1'b0, d}) begin
      t     = t - {1'b0, d};
      nn[0] = 1'b1;
    end
    return {t[DATA_WIDTH-1:0], nn};
  endfunction

  // Applies the sign to a magnitude and saturates when it does not fit.
  function automatic pack_t sat_pack(input logic neg, input logic [PACK_W-1:0] m);
    pack_t               p;
    logic [PACK_W-1:0]   lim;
    lim = neg ? PACK_W'(SIGN_MAG) : PACK_W'(MAX_POS);
    if (m > lim) begin
      p.res = neg ? data_t'(SIGN_MAG) : data_t'(MAX_POS);
      p.st  = ST_SAT;
    end else begin
      p.res = neg ? data_t'(-m[DATA_WIDTH-1:0]) : data_t'(m[DATA_WIDTH-1:0]);
      p.st  = ST_OK;
    end
    return p;
  endfunction

  stage_t stg_r   [DIV_STAGES+1];
  stage_t stg0_nxt;
  stage_t stg_nxt [1:DIV_STAGES];
  logic   vld_r   [DIV_STAGES+1];
  logic   advance;

  data_t  out_res_r, out_res_nxt;
  stat_t  out_st_r, out_st_nxt;
  logic   out_cmp_r, out_cmp_nxt;
  logic   out_valid_r;

  // The whole pipeline moves whenever the result register is free or drains.
  assign advance = !out_valid_r || out_pop;
  assign q_pop   = advance && !q_empty;

  // Entry stage: everything but the multiply packing and the division.
  always_comb begin
    data_t b_eff;
    data_t sum;
    logic  do_sub;
    logic  same;
    logic  a_neg;
    mag_t  fi_lim;
    a_neg  = q_head.a[DATA_WIDTH-1];
    do_sub = (q_head.kind == OP_SUB) || (q_head.kind == OP_DEC);
    b_eff  = ((q_head.kind == OP_INC) || (q_head.kind == OP_DEC)) ? ONE : q_head.b;
    sum    = do_sub ? q_head.a - b_eff : q_head.a + b_eff;
    same   = (a_neg == b_eff[DATA_WIDTH-1]);
    fi_lim = (a_neg ? SIGN_MAG : MAX_POS) >> FRAC_BITS;

    stg0_nxt.kind = q_head.kind;
    stg0_nxt.neg  = q_head.res_neg;
    stg0_nxt.dz   = (q_head.mag_b == '0);
    stg0_nxt.res  = '0;
    stg0_nxt.st   = ST_OK;
    stg0_nxt.cmp  = 1'b0;
    stg0_nxt.prod = q_head.mag_a * q_head.mag_b;
    stg0_nxt.rem  = '0;
    stg0_nxt.num  = NUM_PAD'({q_head.mag_a, {FRAC_BITS{1'b0}}});
    stg0_nxt.dvs  = q_head.mag_b;

    unique case (q_head.kind)
      OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
        if ((do_sub ? !same : same) && (sum[DATA_WIDTH-1] != a_neg)) begin
          stg0_nxt.res = a_neg ? data_t'(SIGN_MAG) : data_t'(MAX_POS);
          stg0_nxt.st  = ST_SAT;
        end else begin
          stg0_nxt.res = sum;
        end
      end
      OP_MUL, OP_DIV: ;
      OP_GT:  stg0_nxt.cmp = (q_head.a >  q_head.b);
      OP_LT:  stg0_nxt.cmp = (q_head.a <  q_head.b);
      OP_GE:  stg0_nxt.cmp = (q_head.a >= q_head.b);
      OP_LE:  stg0_nxt.cmp = (q_head.a <= q_head.b);
      OP_EQ:  stg0_nxt.cmp = (q_head.a == q_head.b);
      OP_NE:  stg0_nxt.cmp = (q_head.a != q_head.b);
      OP_MIN: stg0_nxt.res = (q_head.a < q_head.b) ? q_head.a : q_head.b;
      OP_MAX: stg0_nxt.res = (q_head.a > q_head.b) ? q_head.a : q_head.b;
      OP_FROM_INT: begin
        if (q_head.mag_a > fi_lim) begin
          stg0_nxt.res = a_neg ? data_t'(SIGN_MAG) : data_t'(MAX_POS);
          stg0_nxt.st  = ST_SAT;
        end else begin
          stg0_nxt.res = q_head.a << FRAC_BITS;
        end
      end
      OP_TO_INT: stg0_nxt.res = q_head.a >>> FRAC_BITS;
    endcase
  end

  // Divider stages; the first one also rounds and packs the product.
  always_comb begin
    logic [DATA_WIDTH+NUM_PAD-1:0] s1;
    logic [DATA_WIDTH+NUM_PAD-1:0] s2;
    logic [PACK_W-1:0]             rounded;
    pack_t                         pk;
    rounded = '0;
    pk      = '0;
    for (int k = 1; k <= DIV_STAGES; k++) begin
      stg_nxt[k] = stg_r[k-1];
      s1 = div_step(stg_r[k-1].rem, stg_r[k-1].num, stg_r[k-1].dvs);
      s2 = div_step(s1[DATA_WIDTH+NUM_PAD-1:NUM_PAD], s1[NUM_PAD-1:0], stg_r[k-1].dvs);
      stg_nxt[k].rem = s2[DATA_WIDTH+NUM_PAD-1:NUM_PAD];
      stg_nxt[k].num = s2[NUM_PAD-1:0];
      if ((k == 1) && (stg_r[k-1].kind == OP_MUL)) begin
        rounded        = ({1'b0, stg_r[k-1].prod} + HALF) >> FRAC_BITS;
        pk             = sat_pack(stg_r[k-1].neg, rounded);
        stg_nxt[k].res = pk.res;
        stg_nxt[k].st  = pk.st;
      end
    end
  end

  // Result stage: rounds the quotient half away from zero, flags a zero divisor and passes other results through.
  always_comb begin
    logic [NUM_PAD:0] q;
    logic             up;
    pack_t            pk;
    up          = ({stg_r[DIV_STAGES].rem, 1'b0} >= {1'b0, stg_r[DIV_STAGES].dvs});
    q           = {1'b0, stg_r[DIV_STAGES].num} + (NUM_PAD+1)'(up);
    pk          = sat_pack(stg_r[DIV_STAGES].neg, PACK_W'(q));
    out_res_nxt = stg_r[DIV_STAGES].res;
    out_st_nxt  = stg_r[DIV_STAGES].st;
    out_cmp_nxt = stg_r[DIV_STAGES].cmp;
    if (stg_r[DIV_STAGES].kind == OP_DIV) begin
      if (stg_r[DIV_STAGES].dz) begin
        out_res_nxt = '0;
        out_st_nxt  = ST_DIVZ;
      end else begin
        out_res_nxt = pk.res;
        out_st_nxt  = pk.st;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int k = 0; k <= DIV_STAGES; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (advance) begin
      out_valid_r <= vld_r[DIV_STAGES];
      vld_r[0]    <= !q_empty;
      for (int k = 1; k <= DIV_STAGES; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stg_r[0] <= stg0_nxt;
      for (int k = 1; k <= DIV_STAGES; k++) begin
        stg_r[k] <= stg_nxt[k];
      end
      out_res_r <= out_res_nxt;
      out_st_r  <= out_st_nxt;
      out_cmp_r <= out_cmp_nxt;
    end
  end

  assign out_empty        = !out_valid_r;
  assign out_result       = out_res_r;
  assign out_compare_true = out_cmp_r;
  assign out_status       = out_st_r;

endmodule

// File: hdl/fixed_point_q24_8_alu.sv
// Top level of the Q24.8 fixed-point ALU: front, queue and back end.
// Depends on fxa_pkg, fxa_front, fxa_queue and fxa_back.
//
//   channel  ports                                             transfer when
//   input    in_push in_full in_kind in_operand_a in_operand_b  in_push & !in_full
//   result   out_pop out_empty out_result out_compare_true      out_pop & !out_empty
//            out_status
//
// One item per cycle is sustained while results are popped. Every operation takes
// the same path through the queue, the entry stage, the divider stages and the result
// register; the divider pipeline retires two quotient bits per stage.
// Reset is synchronous and clears the queue and all valid bits.
// A stalled result freezes the back end; the four-entry queue keeps taking input until full.
module fixed_point_q24_8_alu (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  logic [fxa_pkg::KIND_W-1:0]            in_kind,
  input  logic signed [fxa_pkg::DATA_WIDTH-1:0] in_operand_a,
  input  logic signed [fxa_pkg::DATA_WIDTH-1:0] in_operand_b,
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output logic signed [fxa_pkg::DATA_WIDTH-1:0] out_result,
  output logic                                  out_compare_true,
  output logic [fxa_pkg::STAT_W-1:0]            out_status
);
  import fxa_pkg::*;

  logic  q_full;
  logic  q_empty;
  logic  q_push;
  logic  q_pop;
  item_t q_item;
  item_t q_head;

  fxa_front u_front (
    .in_push      (in_push),
    .in_kind      (in_kind),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .in_full      (in_full),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_item)
  );

  fxa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  fxa_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_result       (out_result),
    .out_compare_true (out_compare_true),
    .out_status       (out_status)
  );

endmodule

// File: sim/fxa_checker.sv
`timescale 1ns / 100ps
// Result checker for the Q24.8 fixed-point ALU: predicts each accepted item and
// compares every result transfer in order. Depends on fxa_pkg only.
module fxa_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  input  logic                                  in_full,
  input  logic [fxa_pkg::KIND_W-1:0]            in_kind,
  input  logic signed [fxa_pkg::DATA_WIDTH-1:0] in_operand_a,
  input  logic signed [fxa_pkg::DATA_WIDTH-1:0] in_operand_b,
  input  logic                                  out_empty,
  input  logic                                  out_pop,
  input  logic signed [fxa_pkg::DATA_WIDTH-1:0] out_result,
  input  logic                                  out_compare_true,
  input  logic [fxa_pkg::STAT_W-1:0]            out_status,
  output int                                    fail_count,
  output int                                    pending
);
  import fxa_pkg::*;

  typedef struct {
    data_t result;
    logic  cmp;
    stat_t status;
  } alu_out_t;

  localparam data_t MAX_POS = 32'sh7fffffff;
  localparam data_t MAX_NEG = 32'sh80000000;

  alu_out_t expected_q[$];

  function automatic logic [31:0] magnitude(data_t v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // Signs a magnitude and clamps it to the signed range.
  function automatic alu_out_t sign_clamp(logic neg, logic [63:0] q);
    alu_out_t o;
    logic [63:0] lim;
    o = '{result: '0, cmp: 1'b0, status: ST_OK};
    lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
    if (q > lim) begin
      o.result = neg ? MAX_NEG : MAX_POS;
      o.status = ST_SAT;
    end else begin
      o.result = neg ? -data_t'(q[31:0]) : data_t'(q[31:0]);
    end
    return o;
  endfunction

  function automatic alu_out_t sat_add(data_t a, data_t b, logic sub);
    alu_out_t o;
    logic signed [32:0] wide;
    o = '{result: '0, cmp: 1'b0, status: ST_OK};
    wide = sub ? ({a[31], a} - {b[31], b}) : ({a[31], a} + {b[31], b});
    if (wide > 33'sd2147483647) begin
      o.result = MAX_POS;
      o.status = ST_SAT;
    end else if (wide < -33'sd2147483648) begin
      o.result = MAX_NEG;
      o.status = ST_SAT;
    end else begin
      o.result = wide[31:0];
    end
    return o;
  endfunction

  function automatic alu_out_t predict_alu(op_t op, data_t a, data_t b);
    alu_out_t o;
    logic [63:0] prod, num, den, quo, rem;
    logic [64:0] rounded;
    logic neg;
    o = '{result: '0, cmp: 1'b0, status: ST_OK};
    neg = a[31] ^ b[31];
    case (op)
      OP_ADD: o = sat_add(a, b, 1'b0);
      OP_SUB: o = sat_add(a, b, 1'b1);
      OP_MUL: begin
        prod = 64'(magnitude(a)) * 64'(magnitude(b));
        rounded = 65'(prod) + 65'(1 << (FRAC_BITS - 1));
        o = sign_clamp(neg, 64'(rounded >> FRAC_BITS));
      end
      OP_DIV: begin
        if (b == 0) begin
          o.status = ST_DIVZ;
        end else begin
          num = 64'(magnitude(a)) << FRAC_BITS;
          den = 64'(magnitude(b));
          quo = num / den;
          rem = num % den;
          // Round half away from zero on the magnitude.
          if (rem >= den - rem) quo = quo + 1;
          o = sign_clamp(neg, quo);
        end
      end
      OP_GT: o.cmp = a > b;
      OP_LT: o.cmp = a < b;
      OP_GE: o.cmp = a >= b;
      OP_LE: o.cmp = a <= b;
      OP_EQ: o.cmp = a == b;
      OP_NE: o.cmp = a != b;
      OP_MIN: o.result = (a < b) ? a : b;
      OP_MAX: o.result = (a > b) ? a : b;
      OP_INC: o = sat_add(a, data_t'(1 << FRAC_BITS), 1'b0);
      OP_DEC: o = sat_add(a, data_t'(1 << FRAC_BITS), 1'b1);
      OP_FROM_INT: begin
        if (a > (MAX_POS >>> FRAC_BITS)) begin
          o.result = MAX_POS;
          o.status = ST_SAT;
        end else if (a < (MAX_NEG >>> FRAC_BITS)) begin
          o.result = MAX_NEG;
          o.status = ST_SAT;
        end else begin
          o.result = a <<< FRAC_BITS;
        end
      end
      default: o.result = a >>> FRAC_BITS;
    endcase
    return o;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    alu_out_t exp_item;
    int       errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with no item outstanding");
          errs++;
        end else begin
          exp_item = expected_q.pop_front();
          if (out_result !== exp_item.result) begin
            $error("result: expected %0d, got %0d", exp_item.result, out_result);
            errs++;
          end
          if (out_compare_true !== exp_item.cmp) begin
            $error("compare_true: expected %0b, got %0b", exp_item.cmp, out_compare_true);
            errs++;
          end
          if (out_status !== exp_item.status) begin
            $error("status: expected %0d, got %0d", exp_item.status, out_status);
            errs++;
          end
        end
      end
      if (errs != 0)
        fail_count <= fail_count + errs;
      if (in_push && !in_full)
        expected_q.push_back(predict_alu(op_t'(in_kind), in_operand_a, in_operand_b));
    end
  end

endmodule

// File: sim/tb_fixed_point_q24_8_alu.sv
`timescale 1ns / 100ps
// Testbench top for the Q24.8 fixed-point ALU: drives directed and random items
// with bursty input and stalled output, and gives the verdict from fxa_checker.
module tb_fixed_point_q24_8_alu;
  import fxa_pkg::*;

  localparam int RANDOM_ITEMS = 700;
  localparam int IDLE_LIMIT   = 5000;

  logic  clk;
  logic  rst_n;
  logic  in_push;
  logic  in_full;
  logic [KIND_W-1:0] in_kind;
  data_t in_operand_a;
  data_t in_operand_b;
  logic  out_empty;
  logic  out_pop;
  data_t out_result;
  logic  out_compare_true;
  logic [STAT_W-1:0] out_status;
  int    fail_count;
  int    pending;
  int    idle_cycles;
  int    burst_left;

  fixed_point_q24_8_alu u_dut (.*);

  fxa_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Picks operands from several magnitude classes so saturation and
  // rounding corners come up often.
  function automatic data_t pick_operand();
    case ($urandom_range(0, 5))
      0: return data_t'($urandom());
      1: return data_t'($urandom_range(0, 4096)) - 2048;
      2: case ($urandom_range(0, 5))
           0: return 32'sh7fffffff;
           1: return 32'sh80000000;
           2: return 32'sh007fffff;
           3: return 32'shff800000;
           4: return 0;
           default: return -1;
         endcase
      default: return data_t'($urandom()) >>> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic send_item(op_t op, data_t a, data_t b);
    in_push      <= 1'b1;
    in_kind      <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    forever begin
      @(posedge clk);
      if (!in_full) break;
    end
    // Bursts of back-to-back transfers separated by random gaps.
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      if ($urandom_range(0, 2) != 0) begin
        in_push <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  // Output stalls follow a random mode, picked anew each time mode_timer runs out.
  int stall_mode;
  int mode_timer;
  always @(posedge clk) begin
    if (mode_timer == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_timer <= 50;
    end else begin
      mode_timer <= mode_timer - 1;
    end
    case (stall_mode)
      0: out_pop <= 1'b1;
      1: out_pop <= $urandom_range(0, 1);
      2: out_pop <= ($urandom_range(0, 3) == 0);
      default: out_pop <= ($urandom_range(0, 15) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_push      = 1'b0;
    in_kind      = '0;
    in_operand_a = '0;
    in_operand_b = '0;
    out_pop      = 1'b0;
    stall_mode   = 0;
    mode_timer   = 0;
    idle_cycles  = 0;
    burst_left   = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(OP_ADD, 32'sh7fffffff, 32'sh00000100);
    send_item(OP_ADD, 32'sh80000000, 32'sh80000000);
    send_item(OP_SUB, 32'sh80000000, 32'sh00000001);
    send_item(OP_SUB, 32'sh7fffffff, 32'shffffffff);
    send_item(OP_MUL, 32'sh00000001, 32'sh00000080);
    send_item(OP_MUL, -32'sh00000001, 32'sh00000080);
    send_item(OP_MUL, 32'sh7fffffff, 32'sh7fffffff);
    send_item(OP_MUL, 32'sh80000000, 32'sh00000100);
    send_item(OP_DIV, 32'sh00000300, 32'sh00000000);
    send_item(OP_DIV, 32'sh00000001, 32'sh00000200);
    send_item(OP_DIV, 32'sh80000000, 32'sh00000001);
    send_item(OP_DIV, -32'sh00000100, 32'sh00000300);
    send_item(OP_GT, 32'sh7fffffff, 32'sh80000000);
    send_item(OP_LT, 32'sh7fffffff, 32'sh7ffffffe);
    send_item(OP_GE, 32'sh00000005, 32'sh00000005);
    send_item(OP_LE, 32'sh80000000, 32'sh80000000);
    send_item(OP_EQ, 32'sh01000001, 32'sh01000000);
    send_item(OP_NE, 32'sh01000001, 32'sh01000000);
    send_item(OP_MIN, -32'sh00000007, -32'sh00000007);
    send_item(OP_MAX, 32'sh80000000, 32'sh7fffffff);
    send_item(OP_INC, 32'sh7fffff80, 32'sh00000000);
    send_item(OP_DEC, 32'sh80000010, 32'sh00000000);
    send_item(OP_FROM_INT, 32'sh00800000, 32'sh00000000);
    send_item(OP_FROM_INT, 32'shff800000, 32'sh00000000);
    send_item(OP_TO_INT, -32'sh00000101, 32'sh00000000);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) begin
        // Hold off until the pipeline has fully drained once.
        in_push <= 1'b0;
        while (pending != 0) @(posedge clk);
      end
      send_item(op_t'($urandom_range(0, 15)), pick_operand(), pick_operand());
    end
    in_push <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
